@@ src/pds_pkg.sv @@
// Package for the polyline distance sampler: item kinds, status codes and widths.
// No dependencies.
`timescale 1ns / 1ps
package pds_pkg;
    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_QUERY  = 2'd1,
        K_CLEAR  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_SINGLE = 2'd2;

    localparam int COORD_W = 24;
    localparam int TAN_W   = 16;
    localparam logic [31:0] LEN_SAT = 32'h7FFF_FFFF;
    localparam logic [17:0] ONE_Q14 = 18'd16384;
endpackage

@@ src/pds_seg.sv @@
// Segment length unit: rounded square root of dx*dx + dy*dy, one result bit a step.
// Depends on pds_pkg.
`timescale 1ns / 1ps
module pds_seg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic signed [24:0] i_dx,
    input  logic signed [24:0] i_dy,
    output logic        o_done,
    output logic [25:0] o_len
);
    import pds_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_RND} t_state;

    t_state      r_state;
    logic [24:0] r_ax, r_ay;
    logic [51:0] r_n;
    logic [51:0] r_r;
    logic [51:0] r_bit;
    logic [25:0] r_len;
    logic        r_done;

    logic [49:0] w_sqx, w_sqy;
    assign w_sqx = r_ax * r_ax;
    assign w_sqy = r_ay * r_ay;

    logic [51:0] w_trial;
    assign w_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ax    <= i_dx[24] ? 25'(-i_dx) : i_dx;
                        r_ay    <= i_dy[24] ? 25'(-i_dy) : i_dy;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_n     <= 52'(w_sqx) + 52'(w_sqy);
                    r_r     <= '0;
                    r_bit   <= 52'd1 << 50;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_n >= w_trial) begin
                        r_n <= r_n - w_trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 52'd1) r_state <= S_RND;
                end
                S_RND: begin
                    // n now holds s - r*r.
                    r_len   <= (r_n > r_r) ? 26'(r_r + 52'd1) : 26'(r_r);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_len  = r_len;

    property p_done_pulse;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done held");
    property p_done_from_rnd;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_state) == S_RND;
    endproperty
    a_done_from_rnd: assert property (p_done_from_rnd) else $error("stray done");
    property p_root_width;
        @(posedge i_clk) disable iff (!i_rst_n) r_state == S_ROOT |-> $onehot(r_bit);
    endproperty
    a_root_width: assert property (p_root_width) else $error("bad bit");
endmodule

@@ src/pds_div.sv @@
// Restoring divider: quotient of a 41-bit numerator by a 26-bit divisor, one bit a step.
// Depends on pds_pkg.
`timescale 1ns / 1ps
module pds_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_num,
    input  logic [25:0] i_den,
    output logic        o_done,
    output logic [40:0] o_quo
);
    import pds_pkg::*;

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [40:0] r_q;
    logic [26:0] r_rem;
    logic [25:0] r_den;
    logic [26:0] w_sh;
    assign w_sh = {r_rem[25:0], r_q[40]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= 6'd40;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= {r_q[39:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[39:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

@@ src/polyline_distance_sampler_top.sv @@
// Top level of the polyline distance sampler: command channel, vertex memory, walk sequencer.
// Depends on pds_pkg, pds_seg and pds_div.
`timescale 1ns / 1ps
// Usage
// -----
// One command transaction is taken when i_start is high and o_busy is low. i_kind picks
// the command: append a vertex, run a sample query, or clear the list; the unused code
// is dropped. Append and clear give no result. A query gives exactly one result, shown
// on the o_sample_*, o_tangent_*, o_status and o_overflowed ports for one cycle while
// o_valid is high. The receiver cannot hold results off, so none is ever buffered.
// Clear, and an append to an empty or full list, are done in the idle state. An append to
// a list that already holds a point reads the previous vertex and waits on the bit-serial
// square-root unit that measures the new segment. A query walks the segments one at a
// time; each segment reads one new memory entry and takes the square root. Where the
// walk ends, two 41-step divisions give the tangent. An empty list gives its result
// without a memory read, and a single vertex after one read with no division.
// The vertices live in one synchronous memory with one read per cycle.
// Reset clears the count, the running length and the overflow flag; the memory keeps
// no valid bits since only written entries are ever read. No clearing pass is needed.
module polyline_distance_sampler_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_kind,
    input  logic signed [23:0] i_vertex_x,
    input  logic signed [23:0] i_vertex_y,
    input  logic signed [31:0] i_query_distance,
    output logic        o_busy,
    output logic        o_valid,
    output logic signed [23:0] o_sample_x,
    output logic signed [23:0] o_sample_y,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic [1:0]  o_status,
    output logic        o_overflowed
);
    import pds_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_APP_RD, S_APP_WAIT, S_APP_SEG,
        S_Q_RDA, S_Q_RDB, S_Q_GOTA, S_Q_GOTB, S_Q_SEG, S_Q_DIVX, S_Q_DIVY,
        S_Q_MULX, S_Q_MULY, S_OUT
    } t_state;

    // Vertex memory: x in the upper half, y in the lower half.
    logic [47:0] r_mem [MAX_POINTS];
    logic [47:0] r_rd;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [47:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [31:0]   r_total;
    logic          r_ovf;
    logic [AW-1:0] r_idx;
    logic [31:0]   r_rem;
    logic signed [23:0] r_ax, r_ay, r_bx, r_by;
    logic          r_last;
    logic          r_fallback;
    logic [25:0]   r_len;
    logic signed [17:0] r_tx, r_ty;
    logic signed [23:0] r_sx, r_sy;
    logic [1:0]    r_status;
    logic          r_valid;
    logic          r_seg_go, r_div_go;
    logic signed [24:0] r_dx, r_dy;
    logic [40:0]   r_num;

    logic        w_seg_done;
    logic [25:0] w_seg_len;
    logic        w_div_done;
    logic [40:0] w_quo;

    pds_seg u_seg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_seg_go),
        .i_dx(r_dx), .i_dy(r_dy), .o_done(w_seg_done), .o_len(w_seg_len)
    );

    pds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_num), .i_den(r_len), .o_done(w_div_done), .o_quo(w_quo)
    );

    assign w_we    = (r_state == S_IDLE) && i_start && (t_kind'(i_kind) == K_APPEND)
                     && (r_count < CW'(MAX_POINTS));
    assign w_waddr = AW'(r_count);
    assign w_wdata = {i_vertex_x, i_vertex_y};
    assign w_raddr = r_idx;

    // Tangent magnitude times remaining distance, shifted by 14.
    logic [14:0] w_tmag;
    logic [46:0] w_prod;
    logic signed [17:0] w_tsel;
    assign w_tsel = (r_state == S_Q_MULX) ? r_tx : r_ty;
    assign w_tmag = w_tsel[17] ? 15'(-w_tsel) : 15'(w_tsel);
    assign w_prod = 47'(w_tmag) * 47'(r_rem);
    logic signed [24:0] w_step;
    assign w_step = w_tsel[17] ? -$signed(25'(w_prod[46:14])) : $signed(25'(w_prod[46:14]));

    logic [32:0] w_sum;
    assign w_sum = 33'(r_total) + 33'(w_seg_len);

    logic signed [24:0] w_dxc, w_dyc;
    assign w_dxc = 25'(r_bx) - 25'(r_ax);
    assign w_dyc = 25'(r_by) - 25'(r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_valid  <= 1'b0;
            r_seg_go <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_seg_go <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        case (t_kind'(i_kind))
                            K_APPEND: begin
                                if (r_count >= CW'(MAX_POINTS)) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    r_bx    <= i_vertex_x;
                                    r_by    <= i_vertex_y;
                                    if (r_count != '0) begin
                                        r_idx   <= AW'(r_count - CW'(1));
                                        r_state <= S_APP_RD;
                                    end
                                end
                            end
                            K_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                                r_ovf   <= 1'b0;
                            end
                            K_QUERY: begin
                                r_tx <= '0;
                                r_ty <= '0;
                                r_status <= ST_NORMAL;
                                r_idx <= '0;
                                if (i_query_distance[31]) r_rem <= '0;
                                else if (i_query_distance > $signed(r_total))
                                    r_rem <= r_total;
                                else r_rem <= i_query_distance;
                                if (r_count == '0) begin
                                    r_sx <= '0;
                                    r_sy <= '0;
                                    r_status <= ST_EMPTY;
                                    r_state <= S_OUT;
                                end else if (r_count == CW'(1)) begin
                                    r_status <= ST_SINGLE;
                                    r_tx <= 18'(ONE_Q14);
                                    r_state <= S_Q_RDA;
                                end else begin
                                    r_state <= S_Q_RDA;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_APP_RD: r_state <= S_APP_WAIT;
                S_APP_WAIT: begin
                    r_dx     <= 25'(r_bx) - 25'($signed(r_rd[47:24]));
                    r_dy     <= 25'(r_by) - 25'($signed(r_rd[23:0]));
                    r_seg_go <= 1'b1;
                    r_state  <= S_APP_SEG;
                end
                S_APP_SEG: begin
                    if (w_seg_done) begin
                        r_total <= (w_sum > 33'(LEN_SAT)) ? LEN_SAT : w_sum[31:0];
                        r_state <= S_IDLE;
                    end
                end
                S_Q_RDA: begin
                    r_state <= S_Q_GOTA;
                end
                S_Q_GOTA: begin
                    r_ax <= r_rd[47:24];
                    r_ay <= r_rd[23:0];
                    if (r_status == ST_SINGLE) begin
                        r_sx <= r_rd[47:24];
                        r_sy <= r_rd[23:0];
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= S_Q_RDB;
                    end
                end
                S_Q_RDB: r_state <= S_Q_GOTB;
                S_Q_GOTB: begin
                    r_bx <= r_rd[47:24];
                    r_by <= r_rd[23:0];
                    r_dx <= 25'($signed(r_rd[47:24])) - 25'(r_ax);
                    r_dy <= 25'($signed(r_rd[23:0])) - 25'(r_ay);
                    r_last <= (CW'(r_idx) == r_count - CW'(1));
                    r_seg_go <= 1'b1;
                    r_fallback <= 1'b0;
                    r_state <= S_Q_SEG;
                end
                S_Q_SEG: begin
                    if (w_seg_done) begin
                        if (w_seg_len != '0 && 32'(w_seg_len) >= r_rem) begin
                            r_len <= w_seg_len;
                            r_num <= 41'(w_dxc[24] ? -w_dxc : w_dxc) << 14;
                            r_div_go <= 1'b1;
                            r_state <= S_Q_DIVX;
                        end else if (r_last) begin
                            r_fallback <= 1'b1;
                            r_len <= (w_seg_len < 26'd256) ? 26'd256 : w_seg_len;
                            r_num <= 41'(w_dxc[24] ? -w_dxc : w_dxc) << 14;
                            r_div_go <= 1'b1;
                            r_state <= S_Q_DIVX;
                        end else begin
                            if (w_seg_len != '0) r_rem <= r_rem - 32'(w_seg_len);
                            r_ax <= r_bx;
                            r_ay <= r_by;
                            r_idx <= r_idx + AW'(1);
                            r_state <= S_Q_RDB;
                        end
                    end
                end
                S_Q_DIVX: begin
                    if (w_div_done) begin
                        r_tx <= w_dxc[24] ? -18'(w_quo) : 18'(w_quo);
                        r_num <= 41'(w_dyc[24] ? -w_dyc : w_dyc) << 14;
                        r_div_go <= 1'b1;
                        r_state <= S_Q_DIVY;
                    end
                end
                S_Q_DIVY: begin
                    if (w_div_done) begin
                        r_ty <= w_dyc[24] ? -18'(w_quo) : 18'(w_quo);
                        if (r_fallback) begin
                            r_sx <= r_bx;
                            r_sy <= r_by;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_Q_MULX;
                        end
                    end
                end
                S_Q_MULX: begin
                    r_sx <= 24'(25'(r_ax) + w_step);
                    r_state <= S_Q_MULY;
                end
                S_Q_MULY: begin
                    r_sy <= 24'(25'(r_ay) + w_step);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_sample_x   = r_sx;
    assign o_sample_y   = r_sy;
    assign o_tangent_x  = 16'(r_tx);
    assign o_tangent_y  = 16'(r_ty);
    assign o_status     = r_status;
    assign o_overflowed = r_ovf;

    property p_valid_after_out;
        @(posedge i_clk) disable iff (!i_rst_n) r_valid |-> $past(r_state) == S_OUT;
    endproperty
    a_valid_after_out: assert property (p_valid_after_out) else $error("stray result");
    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(MAX_POINTS);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("count overrun");
    property p_total_sat;
        @(posedge i_clk) disable iff (!i_rst_n) !r_total[31];
    endproperty
    a_total_sat: assert property (p_total_sat) else $error("total over limit");
    property p_empty_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_valid && r_status == ST_EMPTY |-> r_sx == '0 && r_tx == '0;
    endproperty
    a_empty_status: assert property (p_empty_status) else $error("empty result");
endmodule
